@@ sv/arep_pkg.sv @@
package arep_pkg;

    // Default sizes of the parser
    localparam int MARKER_WINDOW_DEF = 12;
    localparam int MAX_ENTRIES_DEF   = 32;

    // Depth of the result queue; two slots are kept free for one request
    localparam int QUEUE_DEPTH = 4;

    // Stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 13;

    // Special words of the event stream
    localparam logic [15:0] WORD_MARKER = 16'hff01;
    localparam logic [15:0] WORD_STOP   = 16'hdddd;
    localparam logic [15:0] WORD_FILLER = 16'hffff;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_SLOT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OVERFLOW_VALUE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNDERFLOW_VALUE = 2'd2;

    // Configuration reset values
    localparam logic [4:0]  TARGET_SLOT_RST     = 5'd9;
    localparam logic [12:0] OVERFLOW_VALUE_RST  = 13'd5000;
    localparam logic [12:0] UNDERFLOW_VALUE_RST = 13'h1c18;  // -1000

    // Record kinds
    localparam logic KIND_HIT = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef enum logic [3:0] {
        PH_LEN     = 4'd0,
        PH_SEEK    = 4'd1,
        PH_BLOCK   = 4'd2,
        PH_HDR_LO  = 4'd3,
        PH_DATA_HI = 4'd4,
        PH_DATA_LO = 4'd5,
        PH_EOB_HI  = 4'd6,
        PH_EOB_LO  = 4'd7,
        PH_IDLE    = 4'd8
    } t_phase;

    // One result record
    typedef struct packed {
        logic               kind;
        logic [4:0]         slot;
        logic [4:0]         chan;
        logic signed [13:0] value;
        logic               mark;
        logic [15:0]        hits;
        logic [23:0]        endc;
        logic [31:0]        evno;
        logic               trunc;
        logic               last;
    } t_rec;

    // Records produced by one request, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

endpackage

@@ sv/arep_out_queue.sv @@
module arep_out_queue
    import arep_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rec  o_rec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_rec             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [CNT_W-1:0] r_count;
    logic             pop;
    logic [PTR_W-1:0] wr_next;

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr_next = PTR_W'(r_wr + PTR_W'(1));

    // Room for the two records one request can make
    assign o_room = (r_count <= CNT_W'(QUEUE_DEPTH - 2));

    // Record storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_next] <= i_push.rec1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= PTR_W'(r_wr + PTR_W'(i_push.cnt));
            r_count <= CNT_W'(r_count + CNT_W'(i_push.cnt) - CNT_W'(pop));
            if (pop) begin
                r_rd <= PTR_W'(r_rd + PTR_W'(1));
            end
        end
    end

endmodule

@@ sv/adc_readout_event_parser_unit.sv @@
// Readout parser for a peak-sensing ADC event stream.
// The slave stream takes one 16-bit word per request: the event length first,
// then the words of the event. The parser looks for the marker word in the
// first MARKER_WINDOW words, then walks the module blocks and emits a hit
// record for each entry of the target slot. The last word of an event emits
// an end-of-event record (tuser = 1) with marker flag, hit count, end-word
// counter, event number and a truncation flag; tlast marks the final record
// of one input word. A record is queued when its word is accepted and leaves
// the master side once the records ahead of it are taken. One word is accepted
// every cycle while s_axis_tready is high; a word that makes both a hit and an
// end record queues both. Records wait in a four-entry queue, and
// s_axis_tready falls while more than two are queued, so a stalled receiver
// stops the input after at most four records. The configuration channel
// writes target slot, overflow and underflow values and is always ready; the
// user must write it only between events, which the parser does not enforce.
// Reset empties the queue, returns to waiting for a length word, clears the
// counters and loads the default configuration.
module adc_readout_event_parser_unit
    import arep_pkg::*;
#(
    parameter int MARKER_WINDOW = MARKER_WINDOW_DEF,
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // word[15:0]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // hit_slot[4:0], hit_channel[9:5], hit_value[23:10], marker_found[24],
    // hit_count[40:25], end_word_count[64:41], event_number[96:65],
    // truncated[97], zero[103:98]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic [0:0]             m_axis_tuser,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ENTRY_W = $clog2(MAX_ENTRIES + 1);

    // Configuration
    logic [4:0]  r_target;
    logic [12:0] r_ovf;
    logic [12:0] r_unf;

    // Parser state
    t_phase               r_phase, n_phase;
    logic [15:0]          r_pos, n_pos;
    logic [15:0]          r_len, n_len;
    logic [4:0]           r_mslot, n_mslot;
    logic [ENTRY_W-1:0]   r_entries, n_entries;
    logic [15:0]          r_pend, n_pend;
    logic                 r_seen, n_seen;
    logic [15:0]          r_hits, n_hits;
    logic [23:0]          r_endc, n_endc;
    logic [31:0]          r_events, n_events;

    logic               in_acc;
    logic [15:0]        word;
    logic               at_end;
    logic               hit_fire;
    logic               trunc;
    logic signed [13:0] hit_value;
    logic [7:0]         hdr_count;
    t_rec               hit_rec;
    t_rec               end_rec;
    t_push              push;
    t_rec               out_rec;
    logic               q_room;

    assign word        = s_axis_tdata;
    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign hdr_count   = word[15:8];

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_SLOT_RST;
            r_ovf    <= OVERFLOW_VALUE_RST;
            r_unf    <= UNDERFLOW_VALUE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                CFG_TARGET_SLOT:     r_target <= i_cfg_data[4:0];
                CFG_OVERFLOW_VALUE:  r_ovf    <= i_cfg_data;
                CFG_UNDERFLOW_VALUE: r_unf    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next parser state for one accepted word
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_len     = r_len;
        n_mslot   = r_mslot;
        n_entries = r_entries;
        n_pend    = r_pend;
        n_seen    = r_seen;
        n_hits    = r_hits;
        n_endc    = r_endc;
        n_events  = r_events;
        at_end    = 1'b0;
        hit_fire  = 1'b0;
        hit_value = '0;
        trunc     = 1'b0;
        if (in_acc) begin
            if (r_phase == PH_LEN) begin
                n_len   = word;
                n_pos   = '0;
                n_seen  = 1'b0;
                n_hits  = '0;
                n_phase = PH_SEEK;
                at_end  = (word == 16'd0);
            end else begin
                n_pos  = r_pos + 16'd1;
                at_end = (n_pos == r_len);
                unique case (r_phase)
                    PH_SEEK: begin
                        priority if (word == WORD_MARKER) begin
                            n_seen  = 1'b1;
                            n_phase = PH_BLOCK;
                        end else if (n_pos >= 16'(MARKER_WINDOW)) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_BLOCK: begin
                        // The last word of the event never opens a block
                        if (!at_end) begin
                            priority if (word == WORD_STOP) begin
                                n_phase = PH_IDLE;
                            end else if (word != WORD_FILLER) begin
                                n_mslot = word[15:11];
                                n_phase = PH_HDR_LO;
                            end
                        end
                    end
                    PH_HDR_LO: begin
                        if (hdr_count > 8'(MAX_ENTRIES)) begin
                            n_entries = ENTRY_W'(MAX_ENTRIES);
                        end else begin
                            n_entries = ENTRY_W'(hdr_count);
                        end
                        n_phase = (n_entries != '0) ? PH_DATA_HI : PH_EOB_HI;
                    end
                    PH_DATA_HI: begin
                        n_pend  = word;
                        n_phase = PH_DATA_LO;
                    end
                    PH_DATA_LO: begin
                        if (r_pend[15:11] == r_mslot && r_mslot == r_target) begin
                            hit_fire = 1'b1;
                            priority if (word[12]) begin
                                hit_value = {1'b0, r_ovf};
                            end else if (word[13]) begin
                                hit_value = {r_unf[12], r_unf};
                            end else begin
                                hit_value = {2'b00, word[11:0]};
                            end
                            if (r_hits != 16'hffff) begin
                                n_hits = r_hits + 16'd1;
                            end
                        end
                        if (r_entries != '0) begin
                            n_entries = r_entries - ENTRY_W'(1);
                        end
                        n_phase = (n_entries != '0) ? PH_DATA_HI : PH_EOB_HI;
                    end
                    PH_EOB_HI: begin
                        n_pend  = word;
                        n_phase = PH_EOB_LO;
                    end
                    PH_EOB_LO: begin
                        // Keep the counter unless slot and end flag match
                        if (r_pend[15:11] == r_mslot && r_pend[10]) begin
                            n_endc = {r_pend[7:0], word};
                        end
                        n_phase = PH_BLOCK;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            if (at_end) begin
                trunc = (n_phase == PH_HDR_LO) || (n_phase == PH_DATA_HI) ||
                        (n_phase == PH_DATA_LO) || (n_phase == PH_EOB_HI) ||
                        (n_phase == PH_EOB_LO);
                n_events = r_events + 32'd1;
                n_phase  = PH_LEN;
            end
        end
    end

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN;
            r_pos     <= '0;
            r_len     <= '0;
            r_mslot   <= '0;
            r_entries <= '0;
            r_pend    <= '0;
            r_seen    <= 1'b0;
            r_hits    <= '0;
            r_endc    <= '0;
            r_events  <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_mslot   <= n_mslot;
            r_entries <= n_entries;
            r_pend    <= n_pend;
            r_seen    <= n_seen;
            r_hits    <= n_hits;
            r_endc    <= n_endc;
            r_events  <= n_events;
        end
    end

    // Build the records of this word; the end record always comes last
    always_comb begin
        hit_rec       = '0;
        hit_rec.kind  = KIND_HIT;
        hit_rec.slot  = r_mslot;
        hit_rec.chan  = r_pend[4:0];
        hit_rec.value = hit_value;
        hit_rec.last  = !at_end;

        end_rec       = '0;
        end_rec.kind  = KIND_END;
        end_rec.mark  = n_seen;
        end_rec.hits  = n_hits;
        end_rec.endc  = n_endc;
        end_rec.evno  = n_events;
        end_rec.trunc = trunc;
        end_rec.last  = 1'b1;

        push = '0;
        priority if (hit_fire && at_end) begin
            push.cnt  = 2'd2;
            push.rec0 = hit_rec;
            push.rec1 = end_rec;
        end else if (hit_fire) begin
            push.cnt  = 2'd1;
            push.rec0 = hit_rec;
        end else if (at_end) begin
            push.cnt  = 2'd1;
            push.rec0 = end_rec;
        end
    end

    arep_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (out_rec)
    );

    assign s_axis_tready   = q_room;
    assign m_axis_tuser[0] = out_rec.kind;
    assign m_axis_tlast    = out_rec.last;
    assign m_axis_tdata    = {6'b000000, out_rec.trunc, out_rec.evno, out_rec.endc,
                              out_rec.hits, out_rec.mark, out_rec.value,
                              out_rec.chan, out_rec.slot};

`ifndef SYNTHESIS
    // An end-of-event record is always the final record of its word
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("end record without tlast");

    // A zero length word makes a record visible in the next cycle
    a_zero_len_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_phase == PH_LEN && s_axis_tdata == 16'd0 |=> m_axis_tvalid)
        else $error("zero length event gave no record");

    // The last word of an event returns the parser to the length word
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && at_end |=> r_phase == PH_LEN)
        else $error("parser did not return to length word");
`endif

endmodule
